// File: design/spdc_pkg.sv
// Shared types and constants for the scheduled portion dispense controller.
// Used by spdc_ctrl, spdc_dp, the top level and the port checker.
`default_nettype none

package spdc_pkg;

    localparam int SLOTS_DEF   = 8;
    localparam int MIN_PER_DAY = 24 * 60;

    // command codes
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_CHECK  = 2'd1;
    localparam logic [1:0] CMD_MANUAL = 2'd2;
    localparam logic [1:0] CMD_WRITE  = 2'd3;

    // feed phases
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_DISP  = 2'd1;
    localparam logic [1:0] PH_PAUSE = 2'd2;

    // event codes
    localparam logic [2:0] EV_NONE  = 3'd0;
    localparam logic [2:0] EV_START = 3'd1;
    localparam logic [2:0] EV_BUSY  = 3'd2;
    localparam logic [2:0] EV_FULL  = 3'd3;
    localparam logic [2:0] EV_DONE  = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_DISP  = 2'd0;
    localparam logic [1:0] CFG_PAUSE = 2'd1;
    localparam logic [1:0] CFG_THR   = 2'd2;
    localparam logic [1:0] CFG_COUNT = 2'd3;

    localparam logic [15:0] DISP_RST  = 16'd2000;
    localparam logic [15:0] PAUSE_RST = 16'd1000;
    localparam logic [15:0] THR_RST   = 16'd200;

    typedef struct packed {
        logic [1:0]         command;
        logic [10:0]        minute_of_day;
        logic signed [15:0] bowl_weight;
        logic               bowl_connected;
        logic [7:0]         portions;
        logic [2:0]         slot_index;
        logic [10:0]        slot_minute;
        logic [7:0]         slot_portions;
    } t_in_word;

    typedef struct packed {
        logic        motor_run;
        logic        feeding;
        logic [7:0]  portions_left;
        logic [2:0]  event_res;
        logic        next_valid;
        logic [10:0] next_slot_minute;
    } t_out_word;

    typedef struct packed {
        logic [10:0] minute;
        logic [7:0]  portions;
    } t_slot;

    // controller to datapath
    typedef struct packed {
        logic load_in;   // latch input word, clear scan
        logic scan_run;  // step the slot scan
        logic commit;    // update feed state, load result word
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_busy;
    } t_dp_sts;

endpackage

`default_nettype wire

// File: design/spdc_dp.sv
// Datapath: configuration registers, feed state, slot table memory, scan and result register.
// Depends on spdc_pkg; driven by spdc_ctrl through t_dp_cmd.
`default_nettype none

module spdc_dp import spdc_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire t_in_word   i_in_word,
    input  wire t_dp_cmd    i_cmd,
    output t_dp_sts         o_sts,
    output t_out_word       o_out_word
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SW = $clog2(SLOTS + 1);

    logic [15:0]        r_cfg_disp, r_cfg_pause;
    logic signed [15:0] r_cfg_thr;
    logic [3:0]         r_cfg_cnt;

    logic [1:0]  r_phase, n_phase;
    logic [15:0] r_elapsed, n_elapsed;
    logic [7:0]  r_remaining, n_remaining;
    logic [10:0] r_last_min;
    logic        r_last_vld;

    t_in_word    r_in;
    t_slot       mem [SLOTS];
    t_slot       r_rd;

    logic [SW-1:0]      r_scan;
    logic               r_pend;
    logic               r_found;
    logic [7:0]         r_found_por;
    logic signed [12:0] r_best;
    logic               r_nvalid;
    logic [10:0]        r_nmin;
    t_out_word          r_out;

    logic [SW-1:0]      used;
    logic               rd_en;
    logic signed [12:0] diff, diff_adj;
    logic               fire;
    logic               feed_go, feed_chk;
    logic [7:0]         feed_por;
    logic [15:0]        el_inc;
    logic [7:0]         rem_dec;
    logic [2:0]         ev;
    logic               wr_ok;

    assign used  = (32'(r_cfg_cnt) > SLOTS) ? SW'(SLOTS) : SW'(r_cfg_cnt);
    assign rd_en = i_cmd.scan_run && (r_scan < used);
    assign o_sts.scan_busy = (r_scan < used) || r_pend;

    assign diff     = $signed({2'b00, r_rd.minute}) - $signed({2'b00, r_in.minute_of_day});
    assign diff_adj = (diff <= 13'sd0) ? diff + 13'(MIN_PER_DAY) : diff;

    assign fire  = r_found && !(r_last_vld && (r_last_min == r_in.minute_of_day));
    assign wr_ok = (32'(r_in.slot_index) < SLOTS);

    // feed start and timer update for the latched word
    always_comb begin
        feed_go     = 1'b0;
        feed_chk    = 1'b0;
        feed_por    = r_in.portions;
        n_phase     = r_phase;
        n_elapsed   = r_elapsed;
        n_remaining = r_remaining;
        ev          = EV_NONE;
        el_inc      = (r_elapsed != 16'hFFFF) ? r_elapsed + 16'd1 : r_elapsed;
        rem_dec     = r_remaining - 8'd1;
        case (r_in.command)
            CMD_TICK: begin
                if (r_phase == PH_DISP) begin
                    n_elapsed = el_inc;
                    if (el_inc >= r_cfg_disp) begin
                        n_remaining = rem_dec;
                        n_elapsed   = 16'd0;
                        if (rem_dec != 8'd0) begin
                            n_phase = PH_PAUSE;
                        end else begin
                            n_phase = PH_IDLE;
                            ev      = EV_DONE;
                        end
                    end
                end else if (r_phase == PH_PAUSE) begin
                    n_elapsed = el_inc;
                    if (el_inc >= r_cfg_pause) begin
                        n_phase   = PH_DISP;
                        n_elapsed = 16'd0;
                    end
                end
            end
            CMD_CHECK: begin
                feed_go  = fire;
                feed_chk = 1'b1;
                feed_por = r_found_por;
            end
            CMD_MANUAL: begin
                feed_go = 1'b1;
            end
            default: begin
            end
        endcase
        if (feed_go) begin
            if (r_phase != PH_IDLE) begin
                ev = EV_BUSY;
            end else if (feed_chk && r_in.bowl_connected &&
                         (r_in.bowl_weight > r_cfg_thr)) begin
                ev = EV_FULL;
            end else begin
                ev          = EV_START;
                n_phase     = PH_DISP;
                n_elapsed   = 16'd0;
                n_remaining = (feed_por == 8'd0) ? 8'd1 : feed_por;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_disp  <= DISP_RST;
            r_cfg_pause <= PAUSE_RST;
            r_cfg_thr   <= THR_RST;
            r_cfg_cnt   <= 4'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DISP:  r_cfg_disp  <= i_cfg_data;
                CFG_PAUSE: r_cfg_pause <= i_cfg_data;
                CFG_THR:   r_cfg_thr   <= i_cfg_data;
                CFG_COUNT: r_cfg_cnt   <= i_cfg_data[3:0];
                default:   r_cfg_cnt   <= r_cfg_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_elapsed   <= 16'd0;
            r_remaining <= 8'd0;
            r_last_min  <= 11'd0;
            r_last_vld  <= 1'b0;
        end else if (i_cmd.commit) begin
            r_phase     <= n_phase;
            r_elapsed   <= n_elapsed;
            r_remaining <= n_remaining;
            if ((r_in.command == CMD_CHECK) && fire) begin
                r_last_min <= r_in.minute_of_day;
                r_last_vld <= 1'b1;
            end
        end
    end

    // scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
            r_pend <= 1'b0;
        end else if (i_cmd.load_in) begin
            r_scan <= '0;
            r_pend <= 1'b0;
        end else if (i_cmd.scan_run) begin
            r_pend <= rd_en;
            if (rd_en) begin
                r_scan <= r_scan + SW'(1);
            end
        end
    end

    // scan accumulators: first match, nearest upcoming slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in        <= i_in_word;
            r_found     <= 1'b0;
            r_found_por <= 8'd0;
            r_best      <= 13'(MIN_PER_DAY + 1);
            r_nvalid    <= 1'b0;
            r_nmin      <= 11'd0;
        end else if (i_cmd.scan_run && r_pend) begin
            if (!r_found && (r_rd.minute == r_in.minute_of_day)) begin
                r_found     <= 1'b1;
                r_found_por <= r_rd.portions;
            end
            if (diff_adj < r_best) begin
                r_best   <= diff_adj;
                r_nvalid <= 1'b1;
                r_nmin   <= r_rd.minute;
            end
        end
    end

    // slot table
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && (r_in.command == CMD_WRITE) && wr_ok) begin
            mem[AW'(r_in.slot_index)] <= '{minute: r_in.slot_minute,
                                           portions: r_in.slot_portions};
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd <= mem[r_scan[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out.motor_run        <= (n_phase == PH_DISP);
            r_out.feeding          <= (n_phase != PH_IDLE);
            r_out.portions_left    <= (n_phase != PH_IDLE) ? n_remaining : 8'd0;
            r_out.event_res        <= ev;
            r_out.next_valid       <= (r_in.command == CMD_CHECK) && r_nvalid;
            r_out.next_slot_minute <= (r_in.command == CMD_CHECK) ? r_nmin : 11'd0;
        end
    end

    assign o_out_word = r_out;

endmodule

`default_nettype wire

// File: design/spdc_ctrl.sv
// Controller state machine: input handshake, scan sequencing, result valid.
// Depends on spdc_pkg; drives spdc_dp through t_dp_cmd.
`default_nettype none

module spdc_ctrl import spdc_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [1:0] i_in_cmd,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    input  wire t_dp_sts    i_sts,
    output t_dp_cmd         o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid;
    logic       out_free;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state       = r_state;
        o_cmd.load_in  = 1'b0;
        o_cmd.scan_run = 1'b0;
        o_cmd.commit   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = (i_in_cmd == CMD_CHECK) ? ST_SCAN : ST_FIN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (!i_sts.scan_busy) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: design/scheduled_portion_dispense_controller.sv
// Top level of the scheduled portion dispense controller.
// Depends on spdc_pkg, spdc_ctrl and spdc_dp.
//
//   channel   direction  signals                               word type
//   input     in         i_in_valid, o_in_stall, i_in_word     t_in_word
//   result    out        o_out_valid, i_out_stall, o_out_word  t_out_word
//   config    in         i_cfg_we, i_cfg_idx, i_cfg_data       16-bit data
//
// Tick, manual feed and slot write go through accept, then commit.
// A time check goes through accept, a scan of the slots in use (min of slot_count and
// SLOTS), then commit; the slot table memory gives one slot per cycle to the scan.
// One word is in flight at a time; o_in_stall is high from acceptance until commit.
// The result register holds a word under i_out_stall while the next one is accepted;
// commit waits only if that register is still full and stalled.
// Reset is synchronous, active low; the slot table holds garbage until written.
`default_nettype none

module scheduled_portion_dispense_controller import spdc_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_word    i_in_word,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_word        o_out_word
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // sequence accept, scan and commit
    spdc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_cmd    (i_in_word.command),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    // hold config, feed state, slot table and result word
    spdc_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_word  (i_in_word),
        .i_cmd      (dp_cmd),
        .o_sts      (dp_sts),
        .o_out_word (o_out_word)
    );

endmodule

`default_nettype wire

// File: design/spdc_checker.sv
// Port-level checker for the scheduled portion dispense controller, bound to the top level.
// Depends on spdc_pkg.
`default_nettype none

module spdc_checker import spdc_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_word o_out_word
);

    // one word in flight: an accepted word stalls the input next cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after acceptance");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("stalled result word changed");

    a_motor_feeding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.motor_run) |-> o_out_word.feeding)
        else $error("motor runs outside a feed");

    a_idle_no_portions: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.feeding) |-> (o_out_word.portions_left == 8'd0))
        else $error("portions left while idle");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.event_res == EV_DONE)) |-> !o_out_word.feeding)
        else $error("feed finished but still feeding");

endmodule

bind scheduled_portion_dispense_controller spdc_checker u_spdc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

`default_nettype wire
